// File: hdl/sats_pkg.sv
`default_nettype none

package sats_pkg;

  localparam int Depth = 32;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int WordW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_A = 3'd0,
    OP_PUSH_B = 3'd1,
    OP_POP_A  = 3'd2,
    OP_POP_B  = 3'd3,
    OP_LIST_A = 3'd4,
    OP_LIST_B = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_RDWAIT = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    emit;
    status_e emit_status;
    logic    push;
    logic    rd_start;
    logic    rd_emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty_a;
    logic empty_b;
    logic full;
    logic slot_free;
    logic rem_last;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/shared_array_two_stacks_unit.sv
// Two stacks in one 32-word store. A push, or a pop or list of an empty stack,
// gets its result from S_EXEC; a pop or a non-empty list reads the store first
// and gets its results from S_RDWAIT. A list then streams one entry per cycle
// while the output is not stalled, paced by the single read port.
// Reset clears both counts and the controller; the store is not cleared.
`default_nettype none

module shared_array_two_stacks_unit
  import sats_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // input channel
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire [2:0]               in_operation_i,
  input  wire signed [WordW-1:0]  in_push_value_i,
  // result channel
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic signed [WordW-1:0] out_word_o,
  output logic [1:0]              out_status_o,
  output logic                    out_last_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: takes one transfer in idle, then sequences the push, the pop
  // read, or the list stream, holding each result until the output slot frees.
  sats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: operand capture, both counts, the shared store with its
  // registered read, list pointer and countdown, and the output register.
  // Only pushed entries are ever read, so the store needs no clearing pass.
  sats_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_operation_i  (in_operation_i),
    .in_push_value_i (in_push_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o),
    .out_status_o    (out_status_o),
    .out_last_o      (out_last_o)
  );

endmodule

`default_nettype wire

// File: hdl/sats_ctrl.sv
`default_nettype none

module sats_ctrl
  import sats_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.emit_status  = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_PUSH_A, OP_PUSH_B: begin
            if (stat_i.slot_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = stat_i.full ? ST_OVERFLOW : ST_OK;
              cmd_o.push        = !stat_i.full;
              state_d           = S_IDLE;
            end
          end
          OP_POP_A, OP_POP_B, OP_LIST_A, OP_LIST_B: begin
            if ((stat_i.op == OP_POP_A || stat_i.op == OP_LIST_A) ? stat_i.empty_a
                                                                  : stat_i.empty_b) begin
              if (stat_i.slot_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = (stat_i.op == OP_POP_A || stat_i.op == OP_POP_B)
                                    ? ST_UNDERFLOW : ST_EMPTY;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_RDWAIT;
            end
          end
          default: begin
            // unused operation code: drop it
            state_d = S_IDLE;
          end
        endcase
      end
      S_RDWAIT: begin
        if (stat_i.slot_free) begin
          cmd_o.rd_emit = 1'b1;
          if (stat_i.rem_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sats_dp.sv
`default_nettype none

module sats_dp
  import sats_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  wire [2:0]               in_operation_i,
  input  wire signed [WordW-1:0]  in_push_value_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic signed [WordW-1:0] out_word_o,
  output logic [1:0]              out_status_o,
  output logic                    out_last_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  op_e              op_q;
  logic [WordW-1:0] val_q;
  logic [CntW-1:0]  count_a_q, count_b_q;
  logic [AddrW-1:0] ptr_q;
  logic [CntW-1:0]  rem_q;

  logic             out_valid_q;
  logic [WordW-1:0] word_q;
  status_e          status_q;
  logic             last_q;

  logic [CntW:0]    total;
  logic             rem_last;
  logic             list_up;
  logic [CntW-1:0]  a_top, b_top, b_free;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  assign total    = {1'b0, count_a_q} + {1'b0, count_b_q};
  assign rem_last = (rem_q == CntW'(1));
  assign list_up  = (op_q == OP_POP_B) || (op_q == OP_LIST_B);
  assign a_top    = count_a_q - CntW'(1);
  assign b_top    = CntW'(Depth) - count_b_q;
  assign b_free   = CntW'(Depth - 1) - count_b_q;

  assign stat_o.op        = op_q;
  assign stat_o.empty_a   = (count_a_q == '0);
  assign stat_o.empty_b   = (count_b_q == '0);
  assign stat_o.full      = (total >= (CntW + 1)'(Depth));
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.rem_last  = rem_last;

  assign rd_en   = cmd_i.rd_start || (cmd_i.rd_emit && !rem_last);
  assign rd_addr = cmd_i.rd_start ? (list_up ? b_top[AddrW-1:0] : a_top[AddrW-1:0])
                                  : (list_up ? ptr_q + AddrW'(1) : ptr_q - AddrW'(1));
  assign wr_addr = (op_q == OP_PUSH_A) ? count_a_q[AddrW-1:0] : b_free[AddrW-1:0];

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(in_operation_i);
      val_q <= in_push_value_i;
    end
  end

  // shared store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ptr_q <= rd_addr;
    end
    if (cmd_i.rd_start) begin
      if (op_q == OP_LIST_A) begin
        rem_q <= count_a_q;
      end else if (op_q == OP_LIST_B) begin
        rem_q <= count_b_q;
      end else begin
        rem_q <= CntW'(1);
      end
    end else if (cmd_i.rd_emit && !rem_last) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      if (cmd_i.push && op_q == OP_PUSH_A) begin
        count_a_q <= count_a_q + CntW'(1);
      end else if (cmd_i.rd_start && op_q == OP_POP_A) begin
        count_a_q <= a_top;
      end
      if (cmd_i.push && op_q == OP_PUSH_B) begin
        count_b_q <= count_b_q + CntW'(1);
      end else if (cmd_i.rd_start && op_q == OP_POP_B) begin
        count_b_q <= count_b_q - CntW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.rd_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      word_q   <= '0;
      status_q <= cmd_i.emit_status;
      last_q   <= 1'b1;
    end else if (cmd_i.rd_emit) begin
      word_q   <= rdata_q;
      status_q <= ST_OK;
      last_q   <= rem_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = word_q;
  assign out_status_o = status_q;
  assign out_last_o   = last_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CntW + 1)'(Depth))
    else $error("stack counts exceed the store depth");

  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_status == ST_OVERFLOW) |=> $stable(total))
    else $error("refused push changed the counts");

  a_stream_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_emit && !rem_last) |=> (rem_q == $past(rem_q) - CntW'(1)))
    else $error("list countdown slipped");

  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit && cmd_i.rd_emit) && !(cmd_i.push && cmd_i.rd_start))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
